@@ design/assert_macros.svh @@
// Assertion macros shared by the sorted set merge RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond holds at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed: invariant");
// cons holds in the same cycle as ante
`define CHK_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: implication");
// cons holds in the cycle after ante
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next cycle");
`else
`define CHK_ALWAYS(lbl, clk, rst, cond)
`define CHK_IMPLIES(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/ssm_pkg.sv @@
// Shared types and constants for the sorted set merge block.
// No dependencies; imported by every module of the block.
package ssm_pkg;

  localparam int SET_DEPTH = 32;
  localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request codes on the input tuser
  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_RUN    = 2'd2;

  // set_mode codes
  localparam logic [1:0] MODE_UNION = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;

  // register index on the config port
  localparam logic REG_SET_MODE = 1'b0;

  localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SCORE_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] row;
    logic [31:0] score;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

@@ design/ssm_front.sv @@
// Front end: takes input words, classifies the request and queues commands.
// Depends on ssm_pkg.
module ssm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [63:0]     s_tdata,   // row_id [31:0], score_in [63:32]
  input  logic [1:0]      s_tuser,   // req_type [1:0]
  output ssm_pkg::q_head_t q_head,
  input  logic            q_pop
);
  import ssm_pkg::*;

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  cmd_t in_cmd;
  logic in_known;
  logic push;
  logic pop;

  always_comb begin
    in_cmd.row   = s_tdata[31:0];
    in_cmd.score = s_tdata[63:32];
    in_known     = 1'b1;
    case (s_tuser)
      REQ_LOAD_A: in_cmd.kind = KIND_LOAD_A;
      REQ_LOAD_B: in_cmd.kind = KIND_LOAD_B;
      REQ_RUN:    in_cmd.kind = KIND_RUN;
      default: begin
        // unused request: accepted and dropped
        in_cmd.kind = KIND_LOAD_A;
        in_known    = 1'b0;
      end
    endcase
  end

  assign s_tready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready && in_known;
  assign pop      = q_pop && (fill != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign q_head.valid = (fill != '0);
  assign q_head.cmd   = queue[rd_ptr];

endmodule

@@ design/ssm_back.sv @@
// Back end: set stores, load handling, two-pointer merge walk and result register.
// Depends on ssm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ssm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       set_mode,
  input  ssm_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [63:0]      m_tdata,   // row_out [31:0], score_out [63:32]
  output logic [1:0]       m_tuser,   // empty_res [0], overflowed [1]
  output logic             m_tlast
);
  import ssm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state;

  logic [63:0] mem_a [SET_DEPTH];
  logic [63:0] mem_b [SET_DEPTH];
  logic [63:0] rd_a;
  logic [63:0] rd_b;

  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic             overflow_flag;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] j_next;

  // pending result, held back one step so last can be marked
  logic        p_valid;
  logic [31:0] p_row;
  logic [31:0] p_score;

  logic [31:0] out_row;
  logic [31:0] out_score;
  logic        out_empty;
  logic        out_ovf;

  logic load_a;
  logic load_b;
  logic start;
  logic out_free;
  logic step;

  logic [31:0] ra, rb, sa, sb;
  logic [32:0] sum;
  logic [31:0] sat;
  logic        a_ok, b_ok;
  logic        emit_new, i_inc, j_inc, done;
  logic [31:0] new_row, new_score;

  assign q_pop  = (state == ST_IDLE) && q_head.valid;
  assign load_a = q_pop && (q_head.cmd.kind == KIND_LOAD_A);
  assign load_b = q_pop && (q_head.cmd.kind == KIND_LOAD_B);
  assign start  = q_pop && (q_head.cmd.kind == KIND_RUN);

  assign out_free = !m_tvalid || m_tready;
  assign step     = (state == ST_MERGE) && out_free;

  assign ra = rd_a[63:32];
  assign sa = rd_a[31:0];
  assign rb = rd_b[63:32];
  assign sb = rd_b[31:0];
  assign a_ok = (i < count_a);
  assign b_ok = (j < count_b);

  assign sum = {sa[31], sa} + {sb[31], sb};
  assign sat = (sum[32] != sum[31]) ? (sum[32] ? SCORE_MIN : SCORE_MAX) : sum[31:0];

  always_comb begin
    emit_new  = 1'b0;
    new_row   = ra;
    new_score = sa;
    i_inc     = 1'b0;
    j_inc     = 1'b0;
    done      = 1'b0;
    if (set_mode > MODE_DIFF) begin
      done = 1'b1;
    end else if (a_ok && b_ok) begin
      if (ra > rb) begin
        emit_new = (set_mode != MODE_INTER);
        i_inc    = 1'b1;
      end else if (ra < rb) begin
        emit_new  = (set_mode == MODE_UNION);
        new_row   = rb;
        new_score = sb;
        j_inc     = 1'b1;
      end else begin
        emit_new  = (set_mode != MODE_DIFF);
        new_score = sat;
        i_inc     = 1'b1;
        j_inc     = 1'b1;
      end
    end else if (a_ok && (set_mode != MODE_INTER)) begin
      emit_new = 1'b1;
      i_inc    = 1'b1;
    end else if (b_ok && (set_mode == MODE_UNION)) begin
      emit_new  = 1'b1;
      new_row   = rb;
      new_score = sb;
      j_inc     = 1'b1;
    end else begin
      done = 1'b1;
    end
  end

  always_comb begin
    i_next = i;
    j_next = j;
    if (state == ST_IDLE || (step && done)) begin
      i_next = '0;
      j_next = '0;
    end else if (step) begin
      if (i_inc) i_next = i + 1'b1;
      if (j_inc) j_next = j + 1'b1;
    end
  end

  // stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (load_a && (count_a < CNT_W'(SET_DEPTH))) begin
      mem_a[count_a[ADDR_W-1:0]] <= {q_head.cmd.row, q_head.cmd.score};
    end
    if (load_b && (count_b < CNT_W'(SET_DEPTH))) begin
      mem_b[count_b[ADDR_W-1:0]] <= {q_head.cmd.row, q_head.cmd.score};
    end
    rd_a <= mem_a[i_next[ADDR_W-1:0]];
    rd_b <= mem_b[j_next[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
      i             <= '0;
      j             <= '0;
      p_valid       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      i <= i_next;
      j <= j_next;
      if (step && (done || (emit_new && p_valid))) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (load_a) begin
            if (count_a < CNT_W'(SET_DEPTH)) count_a <= count_a + 1'b1;
            else overflow_flag <= 1'b1;
          end
          if (load_b) begin
            if (count_b < CNT_W'(SET_DEPTH)) count_b <= count_b + 1'b1;
            else overflow_flag <= 1'b1;
          end
          if (start) state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (step) begin
            if (done) begin
              p_valid       <= 1'b0;
              count_a       <= '0;
              count_b       <= '0;
              overflow_flag <= 1'b0;
              state         <= ST_IDLE;
            end else if (emit_new) begin
              p_valid <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload side of the result register and pending slot
  always_ff @(posedge clk) begin
    if (step) begin
      if (done) begin
        out_row   <= p_valid ? p_row : '0;
        out_score <= p_valid ? p_score : '0;
        out_empty <= !p_valid;
        out_ovf   <= overflow_flag;
        m_tlast   <= 1'b1;
      end else if (emit_new) begin
        if (p_valid) begin
          out_row   <= p_row;
          out_score <= p_score;
          out_empty <= 1'b0;
          out_ovf   <= overflow_flag;
          m_tlast   <= 1'b0;
        end
        p_row   <= new_row;
        p_score <= new_score;
      end
    end
  end

  assign m_tdata = {out_score, out_row};
  assign m_tuser = {out_ovf, out_empty};

  `CHK_ALWAYS(a_cnt_bound, clk, rst, (count_a <= CNT_W'(SET_DEPTH)) && (count_b <= CNT_W'(SET_DEPTH)))
  `CHK_IMPLIES(a_walk_bound, clk, rst, state == ST_MERGE, (i <= count_a) && (j <= count_b))
  `CHK_IMPLIES(a_idle_no_pend, clk, rst, state == ST_IDLE, !p_valid && (i == '0) && (j == '0))
  `CHK_NEXT(a_done_clears, clk, rst, step && done, (state == ST_IDLE) && (count_a == '0) && m_tvalid && m_tlast)

endmodule

@@ design/sorted_set_merge.sv @@
// Top level of the sorted set merge: config register, front queue and back end.
// Depends on ssm_pkg, ssm_front and ssm_back.
//
//  channel  | signals                               | payload
//  ---------+---------------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser     | row_id, score_in; req_type
//  result   | m_tvalid m_tready m_tdata m_tuser     | row_out, score_out; flags
//           | m_tlast                               | last
//  config   | psel penable pwrite paddr pwdata      | set_mode at byte address 0
//           | prdata pready                         |
//
// Loads are taken one word a cycle through the command queue while it has room;
// each that fits in its store is one store write in the back end. A run walks
// both stores at one step a cycle (one registered read per store) unless the
// result side stalls; the queue keeps taking words meanwhile until it is full.
// Reset is synchronous and clears counts, overflow flag and set_mode; store
// contents are undefined until written. Results stall the walk but never drop.
module sorted_set_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // row_id [31:0], score_in [63:32]
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // row_out [31:0], score_out [63:32]
  output logic [1:0]  m_tuser,   // empty_res [0], overflowed [1]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ssm_pkg::*;

  logic [1:0] set_mode;
  q_head_t    q_head;
  logic       q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_mode <= MODE_UNION;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SET_MODE)) begin
      set_mode <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SET_MODE) ? {30'd0, set_mode} : 32'd0;

  ssm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  ssm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .set_mode (set_mode),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ bench/ssm_merge_check_pkg.sv @@
// Scoreboard for the sorted set merge bench: keeps its own copy of both sets,
// predicts the words of every merge run and checks them in order.
// Depends on ssm_pkg.
package ssm_merge_check_pkg;
  import ssm_pkg::*;

  // set_mode code with no merge behind it; the block answers with an empty set
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  typedef struct {
    logic [31:0] row;
    logic [31:0] score;
    logic        empty;
    logic        ovf;
    logic        last;
  } merge_word_t;

  class merge_checker;
    logic [31:0] a_row   [SET_DEPTH];
    logic [31:0] a_score [SET_DEPTH];
    logic [31:0] b_row   [SET_DEPTH];
    logic [31:0] b_score [SET_DEPTH];
    int unsigned a_cnt;
    int unsigned b_cnt;
    logic        dropped;
    logic [1:0]  mode;
    merge_word_t awaited[$];
    int          errors;
    int          matched;

    function new();
      a_cnt   = 0;
      b_cnt   = 0;
      dropped = 1'b0;
      mode    = MODE_UNION;
      errors  = 0;
      matched = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] x, logic [31:0] y);
      logic [32:0] s;
      s = {x[31], x} + {y[31], y};
      if (s[32] != s[31]) return s[32] ? SCORE_MIN : SCORE_MAX;
      return s[31:0];
    endfunction

    function void emit(logic [31:0] row, logic [31:0] score);
      merge_word_t w;
      w.row   = row;
      w.score = score;
      w.empty = 1'b0;
      w.ovf   = dropped;
      w.last  = 1'b0;
      awaited.push_back(w);
    endfunction

    // two-pointer walk over both sets, descending rowids assumed
    function void merge_sets();
      int unsigned i;
      int unsigned j;
      int unsigned first;
      first = awaited.size();
      i = 0;
      j = 0;
      if (mode != MODE_UNUSED) begin
        while (i < a_cnt && j < b_cnt) begin
          if (a_row[i] > b_row[j]) begin
            if (mode != MODE_INTER) emit(a_row[i], a_score[i]);
            i++;
          end else if (a_row[i] < b_row[j]) begin
            if (mode == MODE_UNION) emit(b_row[j], b_score[j]);
            j++;
          end else begin
            if (mode != MODE_DIFF) emit(a_row[i], sat_sum(a_score[i], b_score[j]));
            i++;
            j++;
          end
        end
        if (mode != MODE_INTER) begin
          while (i < a_cnt) begin
            emit(a_row[i], a_score[i]);
            i++;
          end
        end
        if (mode == MODE_UNION) begin
          while (j < b_cnt) begin
            emit(b_row[j], b_score[j]);
            j++;
          end
        end
      end
      if (awaited.size() == first) begin
        emit(32'd0, 32'd0);
        awaited[awaited.size() - 1].empty = 1'b1;
      end
      awaited[awaited.size() - 1].last = 1'b1;
      a_cnt   = 0;
      b_cnt   = 0;
      dropped = 1'b0;
    endfunction

    function void take_word(logic [1:0] req, logic [31:0] row, logic [31:0] score);
      case (req)
        REQ_LOAD_A: begin
          if (a_cnt < SET_DEPTH) begin
            a_row[a_cnt]   = row;
            a_score[a_cnt] = score;
            a_cnt++;
          end else begin
            dropped = 1'b1;
          end
        end
        REQ_LOAD_B: begin
          if (b_cnt < SET_DEPTH) begin
            b_row[b_cnt]   = row;
            b_score[b_cnt] = score;
            b_cnt++;
          end else begin
            dropped = 1'b1;
          end
        end
        REQ_RUN: merge_sets();
        default: ;
      endcase
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [31:0] row, logic [31:0] score, logic empty,
                               logic ovf, logic last);
      merge_word_t w;
      if (awaited.size() == 0) begin
        $error("result word with nothing awaited: row_out %h score_out %h", row, score);
        errors++;
        return;
      end
      w = awaited.pop_front();
      matched++;
      field_check("row_out", w.row, row);
      field_check("score_out", w.score, score);
      field_check("empty_res", 32'(w.empty), 32'(empty));
      field_check("overflowed", 32'(w.ovf), 32'(ovf));
      field_check("last", 32'(w.last), 32'(last));
    endfunction

    function void report_leftovers();
      if (awaited.size() != 0) begin
        $error("%0d result words never arrived", awaited.size());
        errors++;
      end
    endfunction
  endclass

endpackage

@@ bench/tb_sorted_set_merge.sv @@
// Top of the sorted set merge bench: clock, reset, stream and APB drivers.
// Depends on ssm_pkg, ssm_merge_check_pkg and the sorted_set_merge RTL.
module tb_sorted_set_merge;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;
  import ssm_merge_check_pkg::*;

  localparam int ITEM_TARGET   = 310;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // row_id [31:0], score_in [63:32]
  logic [1:0]  s_tuser  = '0;   // req_type [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // row_out [31:0], score_out [63:32]
  logic [1:0]  m_tuser;         // empty_res [0], overflowed [1]
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  merge_checker sb;
  bit calm      = 1'b0;
  bit feeding   = 1'b0;
  bit held      = 1'b0;
  int hold_left = 0;
  int words_sent = 0;

  sorted_set_merge u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // result side: stall pattern, one long hold-off, and the check of each word
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        sb.match_result(m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1], m_tlast);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!held && feeding && m_tvalid && sb.matched >= 40) begin
        held      <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  task automatic send_word(input logic [1:0] req, input logic [31:0] row,
                           input logic [31:0] score);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 16) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {score, row};
    feeding = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.take_word(req, row, score);
    if (req != REQ_UNUSED) words_sent++;
  endtask

  // waits out every awaited word plus the block's own pipeline
  task automatic settle();
    int guard;
    s_tvalid <= 1'b0;
    feeding = 1'b0;
    guard = 0;
    @(posedge clk);
    while (sb.awaited.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SET_MODE, 2'b00};
    pwdata  <= {30'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.mode = m;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 7))
      0: return SCORE_MAX;
      1: return SCORE_MIN;
      2: return 32'($urandom_range(0, 255)) - 32'd128;
      default: return $urandom();
    endcase
  endfunction

  // one merge run: two descending sets sharing some rowids (A jumbled on request), loads interleaved
  task automatic feed_run(input bit overfill, input bit jumbled);
    logic [31:0] pool[$];
    logic [31:0] la_row[$];
    logic [31:0] la_score[$];
    logic [31:0] lb_row[$];
    logic [31:0] lb_score[$];
    logic [31:0] tmp;
    int n, x, y, pick;
    bit to_b, in_a, in_b;
    if (overfill) n = $urandom_range(33, 38);
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(16, 40);
    else n = $urandom_range(0, 10);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: pool.push_back(32'($urandom_range(0, 3)));
        1: pool.push_back(32'hFFFF_FFFF - 32'($urandom_range(0, 3)));
        default: pool.push_back($urandom());
      endcase
    end
    pool.rsort();
    to_b = $urandom_range(0, 1);
    foreach (pool[p]) begin
      pick = $urandom_range(0, 2);
      in_a = (pick != 1) || (overfill && !to_b);
      in_b = (pick != 0) || (overfill && to_b);
      if (in_a) begin
        la_row.push_back(pool[p]);
        la_score.push_back(pick_score());
      end
      if (in_b) begin
        lb_row.push_back(pool[p]);
        lb_score.push_back(pick_score());
      end
    end
    if (jumbled && la_row.size() > 1) begin
      x = $urandom_range(0, la_row.size() - 1);
      y = $urandom_range(0, la_row.size() - 1);
      tmp       = la_row[x];
      la_row[x] = la_row[y];
      la_row[y] = tmp;
    end
    x = 0;
    y = 0;
    while (x < la_row.size() || y < lb_row.size()) begin
      if ($urandom_range(0, 29) == 0) send_word(REQ_UNUSED, $urandom(), $urandom());
      if (y >= lb_row.size() || (x < la_row.size() && $urandom_range(0, 1) == 1)) begin
        send_word(REQ_LOAD_A, la_row[x], la_score[x]);
        x++;
      end else begin
        send_word(REQ_LOAD_B, lb_row[y], lb_score[y]);
        y++;
      end
    end
    send_word(REQ_RUN, $urandom(), $urandom());
  endtask

  initial begin
    int runs;
    int phase;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // union with saturation at both ends and the extreme rowids
    write_mode(MODE_UNION);
    send_word(REQ_LOAD_A, 32'hFFFF_FFFF, SCORE_MAX);
    send_word(REQ_LOAD_B, 32'hFFFF_FFFF, SCORE_MAX);
    send_word(REQ_LOAD_A, 32'd100, 32'd5);
    send_word(REQ_LOAD_B, 32'd50, 32'hFFFF_0000);
    send_word(REQ_LOAD_A, 32'd0, SCORE_MIN);
    send_word(REQ_LOAD_B, 32'd0, SCORE_MIN);
    send_word(REQ_RUN, 32'd0, 32'd0);
    send_word(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // both sets empty
    send_word(REQ_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();

    write_mode(MODE_INTER);
    send_word(REQ_LOAD_A, 32'd10, 32'd1);
    send_word(REQ_LOAD_B, 32'd20, 32'd2);
    send_word(REQ_RUN, 32'd0, 32'd0);
    send_word(REQ_LOAD_A, 32'd30, 32'h0001_0000);
    send_word(REQ_LOAD_A, 32'd10, 32'd1);
    send_word(REQ_LOAD_B, 32'd30, 32'hFFFF_0000);
    send_word(REQ_LOAD_B, 32'd20, 32'd2);
    send_word(REQ_RUN, 32'd0, 32'd0);
    settle();

    write_mode(MODE_DIFF);
    send_word(REQ_LOAD_A, 32'd9, 32'd3);
    send_word(REQ_LOAD_A, 32'd5, 32'd4);
    send_word(REQ_LOAD_B, 32'd7, 32'd6);
    send_word(REQ_LOAD_B, 32'd5, 32'd7);
    send_word(REQ_LOAD_A, 32'd1, 32'd0);
    send_word(REQ_RUN, 32'd0, 32'd0);
    settle();

    write_mode(MODE_UNUSED);
    send_word(REQ_LOAD_A, 32'd7, 32'd1);
    send_word(REQ_LOAD_B, 32'd7, 32'd1);
    send_word(REQ_RUN, 32'd0, 32'd0);
    settle();

    runs  = 0;
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      case (phase % 3)
        0: write_mode(MODE_UNION);
        1: write_mode(MODE_INTER);
        default: write_mode(MODE_DIFF);
      endcase
      repeat (3) begin
        calm = (runs >= 10 && runs < 17);
        feed_run(runs == 0 || $urandom_range(0, 11) == 0,
                 runs == 1 || $urandom_range(0, 9) == 0);
        runs++;
      end
      settle();
      phase++;
    end

    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("tb_sorted_set_merge: clean");
    end else begin
      $display("tb_sorted_set_merge: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sorted_set_merge: errors");
    $finish;
  end

endmodule
